@@ sv/lga_pkg.sv @@
// Shared constants, field widths and codes for the logistic gradient accumulator.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package lga_pkg;

	localparam int MAX_FEATURES  = 64;
	localparam int FRAC_BITS     = 16;
	localparam int OVERFLOW_BITS = 4;

	localparam int DATA_W     = 32;
	localparam int KIND_W     = 2;
	localparam int INDEX_W    = 6;
	localparam int ADDR_W     = $clog2(MAX_FEATURES);
	localparam int COUNT_W    = $clog2(MAX_FEATURES + 1);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int SHIFT_R    = OVERFLOW_BITS + FRAC_BITS;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DRAIN  = 2'd2;

	// result kinds
	localparam logic RES_DOT  = 1'b0;
	localparam logic RES_GRAD = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE          = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 1'd1;

	localparam logic MODE_DOT  = 1'b0;
	localparam logic MODE_GRAD = 1'b1;

	localparam logic [CFG_DATA_W-1:0] FEATURE_COUNT_RST = 7'd64;

endpackage

`default_nettype wire

@@ sv/lga_sample_if.sv @@
// Input channel of the logistic gradient accumulator: valid/ready plus one request.
// Field widths come from lga_pkg.
`default_nettype none

interface lga_sample_if;
	logic                               valid;
	logic                               ready;
	logic [lga_pkg::KIND_W-1:0]         kind;
	logic [lga_pkg::INDEX_W-1:0]        feature_index;
	logic signed [lga_pkg::DATA_W-1:0]  value;
	logic signed [lga_pkg::DATA_W-1:0]  prob;
	logic signed [lga_pkg::DATA_W-1:0]  label;
	logic                               row_end;

	modport source (output valid, kind, feature_index, value, prob, label, row_end,
		input ready);
	modport sink (input valid, kind, feature_index, value, prob, label, row_end,
		output ready);
endinterface

`default_nettype wire

@@ sv/lga_result_if.sv @@
// Output channel of the logistic gradient accumulator: valid/ready plus one result.
// Field widths come from lga_pkg.
`default_nettype none

interface lga_result_if;
	logic                               valid;
	logic                               ready;
	logic                               result_kind;
	logic [lga_pkg::INDEX_W-1:0]        result_index;
	logic signed [lga_pkg::DATA_W-1:0]  result_value;
	logic                               final_res;

	modport source (output valid, result_kind, result_index, result_value, final_res,
		input ready);
	modport sink (input valid, result_kind, result_index, result_value, final_res,
		output ready);
endinterface

`default_nettype wire

@@ sv/logistic_gradient_accumulator_core.sv @@
// Top level of the fixed-point logistic regression kernel: sequencer, shared
// multiply/add unit, weight and gradient memories. Uses lga_pkg, lga_sample_if
// and lga_result_if.
`default_nettype none

// One request is handled at a time. A weight load is written as it is accepted. A
// sample element goes through accept and memory read, operand select, multiply and
// accumulate, and the element that ends a row in dot-product mode adds an emit step
// to present the dot product; this sequence is set by the single 32x32
// multiplier and adder that both modes share, each used once per element.
// A drain of n entries reads and presents each entry in turn: the gradient
// memory has one read port with registered data, so each entry takes a read
// state and an output state. Output back-pressure holds the emit and drain
// output states. There is no clearing pass after reset: per-entry valid bits
// make the gradient store read as zero until written, and a drain clears them all at once.
module logistic_gradient_accumulator_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [lga_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lga_pkg::CFG_DATA_W-1:0]     cfg_data,
	lga_sample_if.sink                              sample,
	lga_result_if.source                            result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_OPER,
		S_MUL,
		S_ACC,
		S_EMIT,
		S_DRAIN_RD,
		S_DRAIN_OUT
	} state_t;

	state_t state_q;

	logic                                mode_q;
	logic [lga_pkg::CFG_DATA_W-1:0]      fcount_q;

	// latched request
	logic [lga_pkg::ADDR_W-1:0]          idx_q;
	logic                                in_range_q;
	logic                                row_end_q;
	logic [lga_pkg::DATA_W-1:0]          val_q;
	logic [lga_pkg::DATA_W-1:0]          prob_q;
	logic [lga_pkg::DATA_W-1:0]          label_q;

	// shared unit operands and result
	logic [lga_pkg::DATA_W-1:0]          opb_q;
	logic [lga_pkg::DATA_W-1:0]          prod_q;
	logic [lga_pkg::DATA_W-1:0]          dot_q;

	logic [lga_pkg::ADDR_W-1:0]          cnt_q;
	logic [lga_pkg::COUNT_W-1:0]         drain_n_q;

	logic [lga_pkg::MAX_FEATURES-1:0]    grad_vld_q;

	// memories
	logic [lga_pkg::DATA_W-1:0]          weight_mem [lga_pkg::MAX_FEATURES];
	logic [lga_pkg::DATA_W-1:0]          grad_mem   [lga_pkg::MAX_FEATURES];
	logic [lga_pkg::DATA_W-1:0]          w_rd_q;
	logic [lga_pkg::DATA_W-1:0]          g_rd_q;
	logic                                g_hit_q;

	// output register
	logic                                out_valid_q;
	logic                                out_kind_q;
	logic [lga_pkg::INDEX_W-1:0]         out_index_q;
	logic [lga_pkg::DATA_W-1:0]          out_value_q;
	logic                                out_final_q;

	logic                                accept;
	logic                                out_free;
	logic                                out_load;
	logic [lga_pkg::ADDR_W-1:0]          in_addr;
	logic                                in_range;
	logic                                w_we;
	logic                                g_we;
	logic                                g_re;
	logic [lga_pkg::ADDR_W-1:0]          g_raddr;
	logic [lga_pkg::DATA_W-1:0]          g_old;
	logic [lga_pkg::DATA_W-1:0]          diff;
	logic signed [lga_pkg::DATA_W-1:0]   term;
	logic [lga_pkg::DATA_W-1:0]          acc_sum;
	logic [lga_pkg::COUNT_W-1:0]         drain_n;
	logic                                drain_last;

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign out_free     = !out_valid_q || result.ready;
	assign out_load     = out_free && ((state_q == S_EMIT) || (state_q == S_DRAIN_OUT));

	assign in_addr  = sample.feature_index[lga_pkg::ADDR_W-1:0];
	assign in_range = (32'(sample.feature_index) < lga_pkg::MAX_FEATURES);

	assign drain_n = (fcount_q > lga_pkg::COUNT_W'(lga_pkg::MAX_FEATURES))
		? lga_pkg::COUNT_W'(lga_pkg::MAX_FEATURES) : fcount_q;
	assign drain_last = ((lga_pkg::COUNT_W'(cnt_q) + 1'b1) == drain_n_q);

	assign diff  = (prob_q - label_q) << lga_pkg::FRAC_BITS;
	assign term  = $signed(prod_q) >>> lga_pkg::SHIFT_R;
	assign g_old = g_hit_q ? g_rd_q : '0;
	// the one adder: dot accumulate in mode 0, gradient update in mode 1
	assign acc_sum = (mode_q == lga_pkg::MODE_DOT) ? (dot_q + prod_q) : (g_old + term);

	assign w_we = accept && (sample.kind == lga_pkg::KIND_LOAD) && in_range;
	assign g_we = (state_q == S_ACC) && (mode_q == lga_pkg::MODE_GRAD) && in_range_q;
	assign g_re = (accept && (sample.kind == lga_pkg::KIND_SAMPLE)) ||
		(state_q == S_DRAIN_RD);
	assign g_raddr = (state_q == S_IDLE) ? in_addr : cnt_q;

	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[in_addr] <= sample.value;
		end
		if (accept && (sample.kind == lga_pkg::KIND_SAMPLE)) begin
			w_rd_q <= weight_mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			grad_mem[idx_q] <= acc_sum;
		end
		if (g_re) begin
			g_rd_q <= grad_mem[g_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (sample.kind == lga_pkg::KIND_SAMPLE)) begin
			idx_q      <= in_addr;
			in_range_q <= in_range;
			row_end_q  <= sample.row_end;
			val_q      <= sample.value;
			prob_q     <= sample.prob;
			label_q    <= sample.label;
		end
		if (state_q == S_OPER) begin
			opb_q <= (mode_q == lga_pkg::MODE_DOT) ? w_rd_q : diff;
		end
		if (state_q == S_MUL) begin
			prod_q <= val_q * opb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= lga_pkg::MODE_DOT;
			fcount_q    <= lga_pkg::FEATURE_COUNT_RST;
			dot_q       <= '0;
			cnt_q       <= '0;
			drain_n_q   <= '0;
			grad_vld_q  <= '0;
			g_hit_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q  <= lga_pkg::RES_DOT;
			out_index_q <= '0;
			out_value_q <= '0;
			out_final_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lga_pkg::REG_MODE:          mode_q   <= cfg_data[0];
					lga_pkg::REG_FEATURE_COUNT: fcount_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && result.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			if (g_re) begin
				g_hit_q <= grad_vld_q[g_raddr];
			end
			if (g_we) begin
				grad_vld_q[idx_q] <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (sample.kind)
							lga_pkg::KIND_SAMPLE: state_q <= S_OPER;
							lga_pkg::KIND_DRAIN: begin
								cnt_q     <= '0;
								drain_n_q <= drain_n;
								if (drain_n == '0) begin
									grad_vld_q <= '0;
								end else begin
									state_q <= S_DRAIN_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_OPER: state_q <= S_MUL;
				S_MUL:  state_q <= S_ACC;
				S_ACC: begin
					if (mode_q == lga_pkg::MODE_DOT) begin
						if (in_range_q) begin
							dot_q <= acc_sum;
						end
						state_q <= row_end_q ? S_EMIT : S_IDLE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= lga_pkg::RES_DOT;
						out_index_q <= '0;
						out_value_q <= dot_q;
						out_final_q <= 1'b1;
						dot_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				S_DRAIN_RD: state_q <= S_DRAIN_OUT;
				S_DRAIN_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= lga_pkg::RES_GRAD;
						out_index_q <= lga_pkg::INDEX_W'(cnt_q);
						out_value_q <= g_old;
						out_final_q <= drain_last;
						if (drain_last) begin
							grad_vld_q <= '0;
							state_q    <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_DRAIN_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_kind  = out_kind_q;
	assign result.result_index = out_index_q;
	assign result.result_value = out_value_q;
	assign result.final_res    = out_final_q;

`ifndef SYNTHESIS
	a_dot_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == lga_pkg::RES_DOT)) |-> out_final_q)
		else $error("dot product result without final mark");

	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DRAIN_OUT) && out_free && drain_last) |=> (grad_vld_q == '0))
		else $error("gradient store not cleared after drain");

	a_cnt_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DRAIN_RD) || (state_q == S_DRAIN_OUT)) |->
		(lga_pkg::COUNT_W'(cnt_q) < drain_n_q))
		else $error("drain counter beyond run length");

	a_emit_clears_dot: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && out_free) |=> (dot_q == '0))
		else $error("dot accumulator not cleared after emit");
`endif

endmodule

`default_nettype wire

@@ tb/tb_logistic_gradient_accumulator_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for logistic_gradient_accumulator_core: directed and random requests,
// a scoreboard class that predicts dot products and gradient drains, random idling on both sides.
// Depends on lga_pkg, lga_sample_if, lga_result_if and the core itself.

module tb_logistic_gradient_accumulator_core;

	localparam logic [lga_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int TIMEOUT_NS    = 4_000_000;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic [lga_pkg::KIND_W-1:0]         kind;
		logic [lga_pkg::INDEX_W-1:0]        feature_index;
		logic signed [lga_pkg::DATA_W-1:0]  value;
		logic signed [lga_pkg::DATA_W-1:0]  prob;
		logic signed [lga_pkg::DATA_W-1:0]  label;
		logic                               row_end;
	} req_t;

	typedef struct packed {
		logic                               kind;
		logic [lga_pkg::INDEX_W-1:0]        index;
		logic signed [lga_pkg::DATA_W-1:0]  value;
		logic                               last;
	} res_t;

	class kernel_scoreboard;
		logic [lga_pkg::DATA_W-1:0]         weights [lga_pkg::MAX_FEATURES];
		logic signed [lga_pkg::DATA_W-1:0]  grads [lga_pkg::MAX_FEATURES];
		logic [lga_pkg::DATA_W-1:0]         dot_sum;
		logic                               mode;
		logic [lga_pkg::CFG_DATA_W-1:0]     feature_count;
		res_t                               due_results [$];
		int                                 mismatches;

		function new();
			for (int i = 0; i < lga_pkg::MAX_FEATURES; i++) begin
				weights[i] = '0;
				grads[i] = '0;
			end
			dot_sum = '0;
			mode = lga_pkg::MODE_DOT;
			feature_count = lga_pkg::FEATURE_COUNT_RST;
			mismatches = 0;
		endfunction

		function void set_reg(logic [lga_pkg::CFG_IDX_W-1:0] idx,
			logic [lga_pkg::CFG_DATA_W-1:0] data);
			if (idx == lga_pkg::REG_MODE)
				mode = data[0];
			else if (idx == lga_pkg::REG_FEATURE_COUNT)
				feature_count = data;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void note_request(req_t r);
			logic signed [lga_pkg::DATA_W-1:0] diff;
			logic signed [lga_pkg::DATA_W-1:0] prod;
			int n;
			case (r.kind)
				lga_pkg::KIND_LOAD: begin
					weights[r.feature_index] = r.value;
				end
				lga_pkg::KIND_SAMPLE: begin
					if (mode == lga_pkg::MODE_DOT) begin
						dot_sum = dot_sum + r.value * weights[r.feature_index];
						if (r.row_end) begin
							due_results.push_back('{lga_pkg::RES_DOT, '0, dot_sum, 1'b1});
							dot_sum = '0;
						end
					end else begin
						// wrap at every step, arithmetic shift on the product
						diff = (r.prob - r.label) <<< lga_pkg::FRAC_BITS;
						prod = r.value * diff;
						grads[r.feature_index] = grads[r.feature_index] +
							(prod >>> lga_pkg::SHIFT_R);
					end
				end
				lga_pkg::KIND_DRAIN: begin
					n = (feature_count > lga_pkg::MAX_FEATURES) ? lga_pkg::MAX_FEATURES :
						int'(feature_count);
					for (int k = 0; k < n; k++)
						due_results.push_back('{lga_pkg::RES_GRAD, lga_pkg::INDEX_W'(k),
							grads[k], k == n - 1});
					for (int k = 0; k < lga_pkg::MAX_FEATURES; k++)
						grads[k] = '0;
				end
				default: ;
			endcase
		endfunction

		function void check_result(res_t got);
			res_t want;
			bit bad;
			bad = 1'b0;
			want = '0;
			if (due_results.size() == 0) begin
				bad = 1'b1;
			end else begin
				want = due_results.pop_front();
				bad = (got.kind !== want.kind) || (got.index !== want.index) ||
					(got.value !== want.value) || (got.last !== want.last);
			end
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t mismatch (due %0d): want kind=%0d idx=%0d val=%h last=%0d",
						$realtime, due_results.size(), want.kind, want.index, want.value,
						want.last);
					$display("%0t mismatch: got kind=%0d idx=%0d val=%h last=%0d",
						$realtime, got.kind, got.index, got.value, got.last);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [lga_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lga_pkg::CFG_DATA_W-1:0] cfg_data;

	lga_sample_if sample_ch ();
	lga_result_if result_ch ();

	logistic_gradient_accumulator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	kernel_scoreboard sb = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic [lga_pkg::MAX_FEATURES-1:0] written = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: check on accept, then pick next ready
	initial begin
		res_t got;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got.kind = result_ch.result_kind;
				got.index = result_ch.result_index;
				got.value = result_ch.result_value;
				got.last = result_ch.final_res;
				sb.check_result(got);
			end
			result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [lga_pkg::DATA_W-1:0] rand_word();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return lga_pkg::DATA_W'($urandom_range(511)) - 32'd256;
			3: return $urandom_range(1) ? 32'hffff_ffff : 32'h0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_req(input logic [lga_pkg::KIND_W-1:0] kind, input int idx,
		input logic [lga_pkg::DATA_W-1:0] value, input logic [lga_pkg::DATA_W-1:0] prob,
		input logic [lga_pkg::DATA_W-1:0] label, input logic row_end);
		req_t r;
		r.kind = kind;
		r.feature_index = lga_pkg::INDEX_W'(idx);
		r.value = value;
		r.prob = prob;
		r.label = label;
		r.row_end = row_end;
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.kind <= r.kind;
		sample_ch.feature_index <= r.feature_index;
		sample_ch.value <= r.value;
		sample_ch.prob <= r.prob;
		sample_ch.label <= r.label;
		sample_ch.row_end <= r.row_end;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		sb.note_request(r);
		if (kind == lga_pkg::KIND_LOAD)
			written[idx] = 1'b1;
	endtask

	task automatic wait_results();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// only while idle: all results in, plus time for a request that emits nothing
	task automatic write_reg(input logic [lga_pkg::CFG_IDX_W-1:0] idx,
		input logic [lga_pkg::CFG_DATA_W-1:0] data);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic run_phase(input logic mode, input logic [lga_pkg::CFG_DATA_W-1:0] fc,
		input int tx, input int rx, input int n_items);
		int cnt;
		int pick;
		int len;
		int idx;
		bit held;
		bit broken;
		logic [lga_pkg::DATA_W-1:0] prob;
		logic [lga_pkg::DATA_W-1:0] label;
		cnt = 0;
		held = 1'b0;
		write_reg(lga_pkg::REG_MODE, lga_pkg::CFG_DATA_W'(mode));
		write_reg(lga_pkg::REG_FEATURE_COUNT, fc);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		while (cnt < n_items) begin
			if (!held && cnt >= n_items / 2) begin
				wait_results();
				held = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 12) begin
				send_req(lga_pkg::KIND_LOAD, $urandom_range(63), rand_word(), $urandom,
					$urandom, 1'($urandom_range(1)));
				cnt++;
			end else if (pick < 17) begin
				send_req(KIND_UNUSED, $urandom_range(63), $urandom, $urandom, $urandom,
					1'($urandom_range(1)));
			end else if (pick < 27) begin
				send_req(lga_pkg::KIND_DRAIN, $urandom_range(63), $urandom, $urandom,
					$urandom, 1'($urandom_range(1)));
				cnt++;
			end else begin
				len = $urandom_range(1, 5);
				broken = ($urandom_range(9) == 0);
				if ($urandom_range(1)) begin
					prob = lga_pkg::DATA_W'($urandom_range(65536));
					label = lga_pkg::DATA_W'($urandom_range(1));
				end else begin
					prob = rand_word();
					label = rand_word();
				end
				for (int j = 0; j < len; j++) begin
					// dot rows only read weights that were loaded
					if (mode == lga_pkg::MODE_DOT) begin
						do idx = $urandom_range(63); while (!written[idx]);
					end else begin
						idx = $urandom_range(63);
					end
					send_req(lga_pkg::KIND_SAMPLE, idx, rand_word(), prob, label,
						(j == len - 1) && !broken);
					cnt++;
				end
			end
		end
	endtask

	initial begin
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.kind <= lga_pkg::KIND_LOAD;
		sample_ch.feature_index <= '0;
		sample_ch.value <= '0;
		sample_ch.prob <= '0;
		sample_ch.label <= '0;
		sample_ch.row_end <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every kind, mode change mid-row, drain lengths
		write_reg(lga_pkg::REG_MODE, lga_pkg::CFG_DATA_W'(lga_pkg::MODE_DOT));
		write_reg(lga_pkg::REG_FEATURE_COUNT, 7'd64);
		send_req(lga_pkg::KIND_LOAD, 0, 32'h7fff_ffff, '0, '0, 1'b0);
		send_req(lga_pkg::KIND_LOAD, 63, 32'h8000_0000, '0, '0, 1'b0);
		send_req(lga_pkg::KIND_LOAD, 1, 32'hffff_ffff, '0, '0, 1'b0);
		send_req(lga_pkg::KIND_LOAD, 2, 32'h0, '0, '0, 1'b0);
		send_req(lga_pkg::KIND_SAMPLE, 0, 32'h7fff_ffff, '0, '0, 1'b0);
		send_req(lga_pkg::KIND_SAMPLE, 63, 32'h8000_0000, '0, '0, 1'b0);
		send_req(lga_pkg::KIND_SAMPLE, 1, 32'hffff_ffff, '0, '0, 1'b1);
		send_req(lga_pkg::KIND_SAMPLE, 2, 32'h0001_2345, '0, '0, 1'b1);
		send_req(KIND_UNUSED, 63, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		send_req(lga_pkg::KIND_DRAIN, 0, '0, '0, '0, 1'b0);
		send_req(lga_pkg::KIND_SAMPLE, 0, 32'd3, '0, '0, 1'b0);
		// accumulator must survive the switch to gradient mode
		write_reg(lga_pkg::REG_MODE, lga_pkg::CFG_DATA_W'(lga_pkg::MODE_GRAD));
		write_reg(lga_pkg::REG_FEATURE_COUNT, 7'd1);
		send_req(lga_pkg::KIND_SAMPLE, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
		send_req(lga_pkg::KIND_SAMPLE, 63, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
		send_req(lga_pkg::KIND_SAMPLE, 0, 32'hffff_ffff, 32'd1, 32'd0, 1'b0);
		send_req(lga_pkg::KIND_DRAIN, 0, '0, '0, '0, 1'b0);
		send_req(lga_pkg::KIND_SAMPLE, 5, 32'd100, 32'd40000, 32'd1, 1'b1);
		write_reg(lga_pkg::REG_FEATURE_COUNT, 7'd0);
		send_req(lga_pkg::KIND_DRAIN, 0, '0, '0, '0, 1'b0);
		write_reg(lga_pkg::REG_FEATURE_COUNT, 7'd127);
		send_req(lga_pkg::KIND_SAMPLE, 3, 32'hffff_fff9, 32'd0, 32'd1, 1'b1);
		send_req(lga_pkg::KIND_DRAIN, 63, '0, '0, '0, 1'b1);
		write_reg(lga_pkg::REG_MODE, lga_pkg::CFG_DATA_W'(lga_pkg::MODE_DOT));
		send_req(lga_pkg::KIND_SAMPLE, 1, 32'd9, '0, '0, 1'b1);
		send_req(lga_pkg::KIND_DRAIN, 0, '0, '0, '0, 1'b0);

		run_phase(lga_pkg::MODE_DOT, 7'd64, 0, 0, 14);
		run_phase(lga_pkg::MODE_GRAD, 7'd64, 75, 0, 16);
		run_phase(lga_pkg::MODE_GRAD, 7'd1, 0, 75, 12);
		run_phase(lga_pkg::MODE_DOT, lga_pkg::CFG_DATA_W'($urandom_range(2, 63)), 17, 17, 14);
		run_phase(lga_pkg::MODE_GRAD, lga_pkg::CFG_DATA_W'($urandom_range(65, 127)), 0, 0, 12);
		run_phase(lga_pkg::MODE_GRAD, 7'd0, 17, 17, 12);

		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
